[rtl/scd_pkg.sv]
// Package for the stereo chorus delay unit: sizes, register map, reset values,
// shared structs and the elaboration-time sine table. No dependencies.
package scd_pkg;

  localparam int STORE_FRAMES = 2048;
  localparam int ADDR_W       = $clog2(STORE_FRAMES);
  localparam int SINE_ENTRIES = 256;
  localparam int SINE_BITS    = $clog2(SINE_ENTRIES);
  localparam int DELAY_W      = ((ADDR_W + 1 > 13) ? ADDR_W + 1 : 13) + 1;

  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [2:0] {
    REG_DRY_GAIN   = 3'd0,
    REG_WET_GAIN   = 3'd1,
    REG_BASE_DELAY = 3'd2,
    REG_MOD_DEPTH  = 3'd3,
    REG_PHASE_STEP = 3'd4
  } reg_idx_t;

  localparam logic [15:0] DRY_GAIN_RST   = 16'd32768;
  localparam logic [15:0] WET_GAIN_RST   = 16'd16384;
  localparam logic [10:0] BASE_DELAY_RST = 11'd1103;
  localparam logic [7:0]  MOD_DEPTH_RST  = 8'd221;
  localparam logic [31:0] PHASE_STEP_RST = 32'd24348;

  typedef struct packed {
    logic [15:0] dry;
    logic [15:0] wet;
  } gain_t;

  typedef struct packed {
    logic [10:0] base_delay;
    logic [7:0]  mod_depth;
    logic [31:0] phase_step;
  } lfo_cfg_t;

  typedef logic signed [15:0] sine_tbl_t [SINE_ENTRIES];

  function automatic logic signed [15:0] sine_of_turn(logic [31:0] a);
    logic [1:0]         quad;
    logic [63:0]        r;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    longint             s;
    longint             q;
    logic signed [15:0] q16;
    quad = a[31:30];
    r = {34'd0, a[29:0]};
    if (quad[0]) r = 64'h4000_0000 - r;
    x  = (r * HALF_PI_Q30) >> 30;
    x2 = (x * x) >> 30;
    s  = longint'(x);
    t  = ((x * x2) >> 30) / 64'd6;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd20;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd42;
    s  = s - longint'(t);
    t  = ((t * x2) >> 30) / 64'd72;
    s  = s + longint'(t);
    t  = ((t * x2) >> 30) / 64'd110;
    s  = s - longint'(t);
    if (s < 0) s = 0;
    q = (s + 16384) >>> 15;
    if (q > 32767) q = 32767;
    q16 = q[15:0];
    return quad[1] ? -q16 : q16;
  endfunction

  function automatic sine_tbl_t build_sine_table();
    sine_tbl_t tbl;
    for (int k = 0; k < SINE_ENTRIES; k++) begin
      tbl[k] = sine_of_turn(32'(64'(k) << (32 - SINE_BITS)));
    end
    return tbl;
  endfunction

  localparam sine_tbl_t SINE_TABLE = build_sine_table();

endpackage

[rtl/scd_if.sv]
// Stream channels of the stereo chorus delay unit: input frames and mixed frames.
// Uses nothing beyond plain logic.
interface scd_audio_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_in;
  logic signed [15:0] right_in;

  modport source (output valid, output left_in, output right_in, input ready);
  modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface scd_mix_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] left_out;
  logic signed [15:0] right_out;

  modport source (output valid, output left_out, output right_out, input ready);
  modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[rtl/scd_frame_store.sv]
// Circular frame store: one write port, one registered read port, and a clearing
// sweep after reset. Depends on scd_pkg.
module scd_frame_store (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [scd_pkg::ADDR_W-1:0] waddr,
  input  logic [31:0]               wdata,
  input  logic                      re,
  input  logic [scd_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]               rdata,
  output logic                      clearing
);

  logic [31:0]              mem [scd_pkg::STORE_FRAMES];
  logic [scd_pkg::ADDR_W:0] clr_cnt;

  assign clearing = !clr_cnt[scd_pkg::ADDR_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_cnt[scd_pkg::ADDR_W-1:0]] <= '0;
    end else if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/scd_position.sv]
// Write pointer, sine LFO and read position of the delay line. The next read
// position is formed at each accepted frame. Depends on scd_pkg.
module scd_position (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  scd_pkg::lfo_cfg_t          cfg,
  output logic [scd_pkg::ADDR_W-1:0] wr,
  output logic [scd_pkg::ADDR_W-1:0] rd
);

  logic [31:0]                       phase;
  logic [31:0]                       phase_next;
  logic signed [15:0]                sine_q;
  logic signed [23:0]                prod;
  logic [22:0]                       prod_abs;
  logic [23:0]                       mag_sum;
  logic [8:0]                        mag;
  logic signed [scd_pkg::DELAY_W-1:0] delay;
  logic signed [scd_pkg::DELAY_W-1:0] delay_sat;
  logic [scd_pkg::ADDR_W-1:0]        wr_next;
  logic [scd_pkg::ADDR_W-1:0]        rd_next;

  assign phase_next = phase + cfg.phase_step;
  assign wr_next    = wr + 1'b1;

  always_comb begin
    prod     = sine_q * $signed({1'b0, cfg.mod_depth});
    prod_abs = prod[23] ? 23'(-prod) : prod[22:0];
    mag_sum  = {1'b0, prod_abs} + 24'd16384;
    mag      = mag_sum[23:15];
    if (prod[23]) begin
      delay = $signed({{(scd_pkg::DELAY_W - 11){1'b0}}, cfg.base_delay})
            - $signed({{(scd_pkg::DELAY_W - 9){1'b0}}, mag});
    end else begin
      delay = $signed({{(scd_pkg::DELAY_W - 11){1'b0}}, cfg.base_delay})
            + $signed({{(scd_pkg::DELAY_W - 9){1'b0}}, mag});
    end
    priority if (delay < 0) begin
      delay_sat = '0;
    end else if (delay > $signed(scd_pkg::DELAY_W'(scd_pkg::STORE_FRAMES - 1))) begin
      delay_sat = scd_pkg::DELAY_W'(scd_pkg::STORE_FRAMES - 1);
    end else begin
      delay_sat = delay;
    end
    rd_next = wr_next - delay_sat[scd_pkg::ADDR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr     <= '0;
      rd     <= '0;
      phase  <= '0;
      sine_q <= scd_pkg::SINE_TABLE[0];
    end else if (accept) begin
      wr     <= wr_next;
      rd     <= rd_next;
      phase  <= phase_next;
      sine_q <= scd_pkg::SINE_TABLE[phase_next[31 -: scd_pkg::SINE_BITS]];
    end
  end

endmodule

[rtl/scd_mix_lane.sv]
// One channel lane: registered dry and wet products, then round and saturate
// to Q1.15. Depends on scd_pkg.
module scd_mix_lane (
  input  logic               clk,
  input  logic               advance,
  input  scd_pkg::gain_t     gains,
  input  logic signed [15:0] sample,
  input  logic signed [15:0] stored,
  output logic signed [15:0] mixed
);

  logic signed [32:0] p_dry;
  logic signed [32:0] p_wet;
  logic signed [33:0] sum;
  logic signed [34:0] rounded;
  logic signed [19:0] scaled;

  always_ff @(posedge clk) begin
    if (advance) begin
      p_dry <= $signed({1'b0, gains.dry}) * sample;
      p_wet <= $signed({1'b0, gains.wet}) * stored;
    end
  end

  always_comb begin
    sum     = 34'(p_dry) + 34'(p_wet);
    rounded = 35'(sum) + 35'sd16384;
    scaled  = rounded[34:15];
    priority if (scaled > 20'sd32767) begin
      mixed = 16'sh7FFF;
    end else if (scaled < -20'sd32768) begin
      mixed = 16'sh8000;
    end else begin
      mixed = scaled[15:0];
    end
  end

endmodule

[rtl/stereo_chorus_delay_unit.sv]
// Stereo chorus: each frame is mixed with a delayed frame whose delay a sine LFO
// sweeps. One frame is accepted per cycle unless the store is clearing or the pipeline
// holds; a frame's result passes the frame store read at the accepting edge, the lane
// products and the output register, and the whole pipeline holds while an output beat
// waits on mix.ready. Rate is set by the frame store, which takes one write and one
// read a cycle. After reset the store is swept to zero, during which no frame is
// accepted; write registers over the APB port only while no frame is in flight.
// Depends on scd_pkg, scd_if, scd_frame_store, scd_position and scd_mix_lane.
module stereo_chorus_delay_unit (
  input  logic                        clk,
  input  logic                        rst,
  scd_audio_if.sink                   audio,
  scd_mix_if.source                   mix,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [scd_pkg::PADDR_W-1:0] paddr,
  input  logic [scd_pkg::PDATA_W-1:0] pwdata,
  output logic [scd_pkg::PDATA_W-1:0] prdata,
  output logic                        pready
);

  logic [15:0] dry_gain;
  logic [15:0] wet_gain;
  logic [10:0] base_delay;
  logic [7:0]  mod_depth;
  logic [31:0] phase_step;
  logic [2:0]  reg_sel;

  logic                       advance;
  logic                       accept;
  logic                       clearing;
  logic [scd_pkg::ADDR_W-1:0] wr;
  logic [scd_pkg::ADDR_W-1:0] rd;
  logic [31:0]                mem_q;

  logic                 v1;
  logic signed [15:0]   in_l;
  logic signed [15:0]   in_r;
  logic                 byp;
  logic signed [15:0]   st_l;
  logic signed [15:0]   st_r;
  logic                 v2;
  logic signed [15:0]   lane_l;
  logic signed [15:0]   lane_r;

  logic                 out_valid;
  logic signed [15:0]   out_l;
  logic signed [15:0]   out_r;

  scd_pkg::gain_t    gains;
  scd_pkg::lfo_cfg_t lfo_cfg;

  assign pready  = 1'b1;
  assign reg_sel = paddr[4:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      dry_gain   <= scd_pkg::DRY_GAIN_RST;
      wet_gain   <= scd_pkg::WET_GAIN_RST;
      base_delay <= scd_pkg::BASE_DELAY_RST;
      mod_depth  <= scd_pkg::MOD_DEPTH_RST;
      phase_step <= scd_pkg::PHASE_STEP_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        scd_pkg::REG_DRY_GAIN:   dry_gain   <= pwdata[15:0];
        scd_pkg::REG_WET_GAIN:   wet_gain   <= pwdata[15:0];
        scd_pkg::REG_BASE_DELAY: base_delay <= pwdata[10:0];
        scd_pkg::REG_MOD_DEPTH:  mod_depth  <= pwdata[7:0];
        scd_pkg::REG_PHASE_STEP: phase_step <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      scd_pkg::REG_DRY_GAIN:   prdata = {16'd0, dry_gain};
      scd_pkg::REG_WET_GAIN:   prdata = {16'd0, wet_gain};
      scd_pkg::REG_BASE_DELAY: prdata = {21'd0, base_delay};
      scd_pkg::REG_MOD_DEPTH:  prdata = {24'd0, mod_depth};
      scd_pkg::REG_PHASE_STEP: prdata = phase_step;
      default:                 prdata = '0;
    endcase
  end

  assign gains   = '{dry: dry_gain, wet: wet_gain};
  assign lfo_cfg = '{base_delay: base_delay, mod_depth: mod_depth, phase_step: phase_step};

  assign advance     = !out_valid || mix.ready;
  assign audio.ready = advance && !clearing;
  assign accept      = audio.valid && audio.ready;

  scd_position u_position (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .cfg    (lfo_cfg),
    .wr     (wr),
    .rd     (rd)
  );

  scd_frame_store u_store (
    .clk      (clk),
    .rst      (rst),
    .we       (accept),
    .waddr    (wr),
    .wdata    ({audio.right_in, audio.left_in}),
    .re       (advance),
    .raddr    (rd),
    .rdata    (mem_q),
    .clearing (clearing)
  );

  // hold the frame alongside the store read; forward it when read hits write
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      in_l <= audio.left_in;
      in_r <= audio.right_in;
      byp  <= (rd == wr);
    end
  end

  assign st_l = byp ? in_l : mem_q[15:0];
  assign st_r = byp ? in_r : mem_q[31:16];

  scd_mix_lane u_lane_l (
    .clk     (clk),
    .advance (advance),
    .gains   (gains),
    .sample  (in_l),
    .stored  (st_l),
    .mixed   (lane_l)
  );

  scd_mix_lane u_lane_r (
    .clk     (clk),
    .advance (advance),
    .gains   (gains),
    .sample  (in_r),
    .stored  (st_r),
    .mixed   (lane_r)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // merge both lanes into one output beat
  always_ff @(posedge clk) begin
    if (advance) begin
      out_l <= lane_l;
      out_r <= lane_r;
    end
  end

  assign mix.valid     = out_valid;
  assign mix.left_out  = out_l;
  assign mix.right_out = out_r;

endmodule
